### rtl/core/agr_pkg.sv
// shared types, codes and blend helpers for the glyph renderer
package agr_pkg;

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_CHAR   = 2'd1;
   localparam logic [1:0] CMD_HEADER = 2'd2;
   localparam logic [1:0] CMD_DATA   = 2'd3;

   localparam logic [1:0] KIND_FETCH  = 2'd0;
   localparam logic [1:0] KIND_WINDOW = 2'd1;
   localparam logic [1:0] KIND_PIXEL  = 2'd2;

   localparam int WQ_DEPTH   = 2;
   localparam int WQ_AW      = $clog2(WQ_DEPTH);
   localparam int WQ_CW      = $clog2(WQ_DEPTH + 1);
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

   // x / 15 as (x * 2185) >> 15, exact for x below 1024
   localparam logic [11:0] DIV15_MUL   = 12'd2185;
   localparam int          DIV15_SHIFT = 15;
   localparam logic [3:0]  COV_FULL    = 4'd15;

   typedef enum logic [1:0] {
      WORK_FETCH,
      WORK_WINDOW,
      WORK_PIXELS
   } work_op_type;

   typedef struct packed {
      logic [15:0] fg_color;
      logic [15:0] bg_color;
      logic [7:0]  origin_x;
      logic [7:0]  baseline_y;
      logic [1:0]  font_select;
   } csr_type;

   typedef struct packed {
      work_op_type op;
      logic [6:0]  glyph_index;
      logic        font_id;
      logic [7:0]  win_x;
      logic [7:0]  win_y;
      logic [7:0]  win_w;
      logic [7:0]  win_h;
      logic [7:0]  data_byte;
      logic        pix_two;
      logic        pix_last;
   } work_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  glyph_index;
      logic        font_id;
      logic [7:0]  win_x;
      logic [7:0]  win_y;
      logic [7:0]  win_w;
      logic [7:0]  win_h;
      logic [15:0] pixel;
      logic        last;
   } rsp_type;

   function automatic logic [9:0] chan_sum(input logic [5:0] fg_chan,
                                           input logic [5:0] bg_chan,
                                           input logic [3:0] cov);
      logic [3:0] inv;
      inv = COV_FULL - cov;
      return ({4'd0, fg_chan} * {6'd0, cov}) + ({4'd0, bg_chan} * {6'd0, inv});
   endfunction

   function automatic logic [5:0] div15(input logic [9:0] sum);
      logic [21:0] prod;
      prod = {12'd0, sum} * {10'd0, DIV15_MUL};
      return prod[DIV15_SHIFT +: 6];
   endfunction

endpackage

### rtl/core/antialiased_glyph_renderer.sv
// text to rgb565 renderer: fetch requests, glyph windows and blended pixels
// path: a request is accepted, reaches the work queue, is issued to the
//   blend stage and lands in the result queue
// throughput: one result per cycle from the back end while the result queue
//   has room; data requests give two pixels (one if one is left), others one
// reset: synchronous; queues empty, pen and pixel count zero, registers at defaults
module antialiased_glyph_renderer (
   input  logic         clock,
   input  logic         reset,

   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata,

   input  logic         req_push,
   output logic         req_full,
   input  logic [1:0]   req_cmd,
   input  logic [7:0]   req_char_code,
   input  logic [7:0]   req_glyph_width,
   input  logic [7:0]   req_glyph_height,
   input  logic [7:0]   req_advance,
   input  logic [7:0]   req_bearing_x,
   input  logic [7:0]   req_bearing_y,
   input  logic [7:0]   req_data_byte,

   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [1:0]   rsp_kind,
   output logic [6:0]   rsp_glyph_index,
   output logic         rsp_font_id,
   output logic [7:0]   rsp_win_x,
   output logic [7:0]   rsp_win_y,
   output logic [7:0]   rsp_win_w,
   output logic [7:0]   rsp_win_h,
   output logic [15:0]  rsp_pixel,
   output logic         rsp_last
);

   localparam logic [2:0] CSR_FG_COLOR    = 3'd0;
   localparam logic [2:0] CSR_BG_COLOR    = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_X    = 3'd2;
   localparam logic [2:0] CSR_BASELINE_Y  = 3'd3;
   localparam logic [2:0] CSR_FONT_SELECT = 3'd4;

   agr_pkg::csr_type   csr_ff, csr_in;
   logic               wq_push;
   agr_pkg::work_type  wq_data;
   logic               wq_full;
   logic               wq_valid;
   agr_pkg::work_type  wq_head;
   logic               wq_pop;
   agr_pkg::rsp_type   rsp;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FG_COLOR:    csr_in.fg_color    = csr_wdata;
            CSR_BG_COLOR:    csr_in.bg_color    = csr_wdata;
            CSR_ORIGIN_X:    csr_in.origin_x    = csr_wdata[7:0];
            CSR_BASELINE_Y:  csr_in.baseline_y  = csr_wdata[7:0];
            CSR_FONT_SELECT: csr_in.font_select = csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.fg_color    <= 16'hFFFF;
         csr_ff.bg_color    <= 16'h0000;
         csr_ff.origin_x    <= 8'd0;
         csr_ff.baseline_y  <= 8'd0;
         csr_ff.font_select <= 2'd0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   agr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr              (csr_ff),
      .req_push         (req_push),
      .wq_full          (wq_full),
      .req_cmd          (req_cmd),
      .req_char_code    (req_char_code),
      .req_glyph_width  (req_glyph_width),
      .req_glyph_height (req_glyph_height),
      .req_advance      (req_advance),
      .req_bearing_x    (req_bearing_x),
      .req_bearing_y    (req_bearing_y),
      .req_data_byte    (req_data_byte),
      .wq_push          (wq_push),
      .wq_data          (wq_data)
   );

   agr_workq u_workq (
      .clock     (clock),
      .reset     (reset),
      .push      (wq_push),
      .push_data (wq_data),
      .pop       (wq_pop),
      .full      (wq_full),
      .valid     (wq_valid),
      .head      (wq_head)
   );

   agr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .wq_valid  (wq_valid),
      .wq_head   (wq_head),
      .wq_pop    (wq_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign req_full        = wq_full;
   assign rsp_kind        = rsp.kind;
   assign rsp_glyph_index = rsp.glyph_index;
   assign rsp_font_id     = rsp.font_id;
   assign rsp_win_x       = rsp.win_x;
   assign rsp_win_y       = rsp.win_y;
   assign rsp_win_w       = rsp.win_w;
   assign rsp_win_h       = rsp.win_h;
   assign rsp_pixel       = rsp.pixel;
   assign rsp_last        = rsp.last;

endmodule

### rtl/core/agr_front.sv
// front end: filters requests, tracks pen and pixel count, emits work entries
module agr_front (
   input  logic               clock,
   input  logic               reset,
   input  agr_pkg::csr_type   csr,
   input  logic               req_push,
   input  logic               wq_full,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_char_code,
   input  logic [7:0]         req_glyph_width,
   input  logic [7:0]         req_glyph_height,
   input  logic [7:0]         req_advance,
   input  logic [7:0]         req_bearing_x,
   input  logic [7:0]         req_bearing_y,
   input  logic [7:0]         req_data_byte,
   output logic               wq_push,
   output agr_pkg::work_type  wq_data
);

   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_TILDE      = 8'h7E;
   localparam logic [7:0] CHAR_LEAD_MIN   = 8'hC0;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   logic [7:0]  pen_x_ff, pen_x_in;
   logic [15:0] pixels_left_ff, pixels_left_in;
   logic        aborted_ff, aborted_in;

   logic        accept;
   logic        char_print;
   logic        char_lead;
   logic [7:0]  char_mapped;
   logic [7:0]  char_offset;
   logic [15:0] glyph_area;

   always_comb begin
      accept      = req_push && !wq_full;
      char_print  = (req_char_code >= CHAR_SPACE) && (req_char_code <= CHAR_TILDE);
      char_lead   = req_char_code >= CHAR_LEAD_MIN;
      char_mapped = char_print ? req_char_code : CHAR_UNDERSCORE;
      char_offset = char_mapped - CHAR_SPACE;
      glyph_area  = {8'd0, req_glyph_width} * {8'd0, req_glyph_height};

      pen_x_in       = pen_x_ff;
      pixels_left_in = pixels_left_ff;
      aborted_in     = aborted_ff;
      wq_push        = 1'b0;
      wq_data        = '0;

      if (accept) begin
         unique case (req_cmd)
            agr_pkg::CMD_START: begin
               pen_x_in       = csr.origin_x;
               pixels_left_in = '0;
               aborted_in     = 1'b0;
            end
            agr_pkg::CMD_CHAR: begin
               if (!aborted_ff && (char_print || char_lead)) begin
                  if (csr.font_select[1]) begin
                     aborted_in = 1'b1;
                  end else begin
                     wq_push             = 1'b1;
                     wq_data.op          = agr_pkg::WORK_FETCH;
                     wq_data.glyph_index = char_offset[6:0];
                     wq_data.font_id     = csr.font_select[0];
                  end
               end
            end
            agr_pkg::CMD_HEADER: begin
               if (!aborted_ff) begin
                  if ((req_glyph_width != 8'd0) && (req_glyph_height != 8'd0)) begin
                     wq_push        = 1'b1;
                     wq_data.op     = agr_pkg::WORK_WINDOW;
                     wq_data.win_x  = pen_x_ff + req_bearing_x;
                     wq_data.win_y  = csr.baseline_y - req_bearing_y;
                     wq_data.win_w  = req_glyph_width;
                     wq_data.win_h  = req_glyph_height;
                     pixels_left_in = glyph_area;
                  end else begin
                     pixels_left_in = '0;
                  end
                  pen_x_in = pen_x_ff + req_advance;
               end
            end
            agr_pkg::CMD_DATA: begin
               if (!aborted_ff && (pixels_left_ff != 16'd0)) begin
                  wq_push           = 1'b1;
                  wq_data.op        = agr_pkg::WORK_PIXELS;
                  wq_data.data_byte = req_data_byte;
                  wq_data.pix_two   = pixels_left_ff != 16'd1;
                  wq_data.pix_last  = pixels_left_ff == 16'd2;
                  pixels_left_in    = (pixels_left_ff != 16'd1) ?
                                      pixels_left_ff - 16'd2 : 16'd0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff       <= '0;
         pixels_left_ff <= '0;
         aborted_ff     <= 1'b0;
      end else begin
         pen_x_ff       <= pen_x_in;
         pixels_left_ff <= pixels_left_in;
         aborted_ff     <= aborted_in;
      end
   end

endmodule

### rtl/core/agr_workq.sv
// short queue of work entries between front and back
module agr_workq (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  agr_pkg::work_type  push_data,
   input  logic               pop,
   output logic               full,
   output logic               valid,
   output agr_pkg::work_type  head
);

   agr_pkg::work_type             entry_ff [agr_pkg::WQ_DEPTH];
   logic [agr_pkg::WQ_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [agr_pkg::WQ_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [agr_pkg::WQ_CW-1:0]     count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   always_comb begin
      full      = count_ff == agr_pkg::WQ_CW'(agr_pkg::WQ_DEPTH);
      valid     = count_ff != '0;
      head      = entry_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + agr_pkg::WQ_CW'(do_push) - agr_pkg::WQ_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/agr_back.sv
// back end: expands work entries into results, blends pixels, result queue
module agr_back (
   input  logic               clock,
   input  logic               reset,
   input  agr_pkg::csr_type   csr,
   input  logic               wq_valid,
   input  agr_pkg::work_type  wq_head,
   output logic               wq_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output agr_pkg::rsp_type   rsp
);

   logic                          phase_ff, phase_in;
   logic                          s1_valid_ff;
   agr_pkg::rsp_type              s1_rsp_ff, s1_rsp_in;
   logic [9:0]                    s1_sum_r_ff, s1_sum_g_ff, s1_sum_b_ff;
   logic [9:0]                    sum_r, sum_g, sum_b;

   agr_pkg::rsp_type              outq_ff [agr_pkg::OUTQ_DEPTH];
   logic [agr_pkg::OUTQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [agr_pkg::OUTQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [agr_pkg::OUTQ_CW-1:0]   count_ff, count_in;
   logic [agr_pkg::OUTQ_CW:0]     occupancy;

   logic                          issue;
   logic                          pair;
   logic [3:0]                    cov;
   logic [5:0]                    div_r, div_g, div_b;
   agr_pkg::rsp_type              s2_rsp;
   logic                          out_pop;

   // issue one result per cycle while the result queue has room
   always_comb begin
      occupancy = {1'b0, count_ff} + {{agr_pkg::OUTQ_CW{1'b0}}, s1_valid_ff};
      issue     = wq_valid && (occupancy < (agr_pkg::OUTQ_CW + 1)'(agr_pkg::OUTQ_DEPTH));
      pair      = (wq_head.op == agr_pkg::WORK_PIXELS) && wq_head.pix_two;
      cov       = phase_ff ? wq_head.data_byte[3:0] : wq_head.data_byte[7:4];
      wq_pop    = issue && (!pair || phase_ff);
      phase_in  = (issue && pair) ? !phase_ff : phase_ff;

      sum_r = agr_pkg::chan_sum({1'b0, csr.fg_color[15:11]}, {1'b0, csr.bg_color[15:11]}, cov);
      sum_g = agr_pkg::chan_sum(csr.fg_color[10:5], csr.bg_color[10:5], cov);
      sum_b = agr_pkg::chan_sum({1'b0, csr.fg_color[4:0]}, {1'b0, csr.bg_color[4:0]}, cov);

      s1_rsp_in = '0;
      unique case (wq_head.op)
         agr_pkg::WORK_FETCH: begin
            s1_rsp_in.kind        = agr_pkg::KIND_FETCH;
            s1_rsp_in.glyph_index = wq_head.glyph_index;
            s1_rsp_in.font_id     = wq_head.font_id;
         end
         agr_pkg::WORK_WINDOW: begin
            s1_rsp_in.kind  = agr_pkg::KIND_WINDOW;
            s1_rsp_in.win_x = wq_head.win_x;
            s1_rsp_in.win_y = wq_head.win_y;
            s1_rsp_in.win_w = wq_head.win_w;
            s1_rsp_in.win_h = wq_head.win_h;
         end
         agr_pkg::WORK_PIXELS: begin
            s1_rsp_in.kind = agr_pkg::KIND_PIXEL;
            s1_rsp_in.last = wq_head.pix_two ? (phase_ff && wq_head.pix_last) : 1'b1;
         end
         default: begin
         end
      endcase
   end

   // divide by 15 and pack the pixel
   always_comb begin
      div_r  = agr_pkg::div15(s1_sum_r_ff);
      div_g  = agr_pkg::div15(s1_sum_g_ff);
      div_b  = agr_pkg::div15(s1_sum_b_ff);
      s2_rsp = s1_rsp_ff;
      if (s1_rsp_ff.kind == agr_pkg::KIND_PIXEL) begin
         s2_rsp.pixel = {div_r[4:0], div_g, div_b[4:0]};
      end
   end

   always_comb begin
      rsp_empty = count_ff == '0;
      rsp       = outq_ff[rd_ptr_ff];
      out_pop   = rsp_pop && !rsp_empty;
      wr_ptr_in = s1_valid_ff ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = out_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + agr_pkg::OUTQ_CW'(s1_valid_ff) - agr_pkg::OUTQ_CW'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         s1_valid_ff <= issue;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_rsp_ff   <= s1_rsp_in;
         s1_sum_r_ff <= sum_r;
         s1_sum_g_ff <= sum_g;
         s1_sum_b_ff <= sum_b;
      end
      if (s1_valid_ff) begin
         outq_ff[wr_ptr_ff] <= s2_rsp;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= agr_pkg::OUTQ_CW'(agr_pkg::OUTQ_DEPTH))
      else $error("result queue count out of range");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (count_ff < agr_pkg::OUTQ_CW'(agr_pkg::OUTQ_DEPTH)))
      else $error("blend stage result has no reserved slot");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (wq_valid && (wq_head.op == agr_pkg::WORK_PIXELS) && wq_head.pix_two))
      else $error("second pixel phase without a pixel pair at queue head");

   assert property (@(posedge clock) disable iff (reset)
      (wq_pop && (wq_head.op == agr_pkg::WORK_PIXELS) && wq_head.pix_two) |-> phase_ff)
      else $error("pixel pair popped before its second pixel");
`endif

endmodule
